// ===== sv/rbc_pkg.sv =====
// ----------------------------------------------------------------------------
// rbc_pkg
// Shared types and constants of the retry backoff controller.
// ----------------------------------------------------------------------------
package rbc_pkg;

  localparam int unsigned DelayW   = 16;
  localparam int unsigned FactorW  = 16;
  localparam int unsigned FracW    = 8;
  localparam int unsigned CountW   = 8;
  localparam int unsigned StatusW  = 10;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned ProdW    = DelayW + FactorW;
  localparam int unsigned ScaledW  = ProdW - FracW;

  // Register reset values
  localparam logic [DelayW-1:0]  MinDelayRst  = 16'd1;
  localparam logic [DelayW-1:0]  MaxDelayRst  = 16'hFFFF;
  localparam logic [FactorW-1:0] FactorRst    = 16'd512;
  localparam logic [CountW-1:0]  MaxRetryRst  = 8'd3;
  localparam logic               ClientErrRst = 1'b0;

  localparam logic [StatusW-1:0] ServerErrLo = 10'd500;
  localparam logic [StatusW-1:0] ServerErrHi = 10'd599;
  localparam logic [DelayW-1:0]  WaitNever   = 16'hFFFF;
  localparam logic [CountW-1:0]  CountMax    = 8'hFF;

  typedef enum logic [ModeW-1:0] {
    MODE_TICK    = 2'd0,
    MODE_SUCCESS = 2'd1,
    MODE_FAILURE = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_DELAY      = 3'd0,
    CFG_MAX_DELAY      = 3'd1,
    CFG_BACKOFF_FACTOR = 3'd2,
    CFG_MAX_RETRIES    = 3'd3,
    CFG_RETRY_CLIENT   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [DelayW-1:0]  delay_floor;
    logic [DelayW-1:0]  delay_ceiling;
    logic [FactorW-1:0] growth_factor;
    logic [CountW-1:0]  retry_limit;
    logic               retry_client_errors;
  } cfg_t;

  typedef struct packed {
    logic [DelayW-1:0] current_delay;
    logic [CountW-1:0] failure_count;
    logic              may_retry;
    logic [DelayW-1:0] countdown;
  } state_t;

  typedef struct packed {
    logic [ModeW-1:0]   mode;
    logic [StatusW-1:0] status_code;
    logic               has_server_wait;
    logic [DelayW-1:0]  server_wait;
  } item_t;

  typedef struct packed {
    logic              retry_allowed;
    logic [DelayW-1:0] wait_left;
    logic [CountW-1:0] failures_seen;
  } result_t;

endpackage

// ===== sv/rbc_if.sv =====
// ----------------------------------------------------------------------------
// rbc_if
// Event and result channels of the retry backoff controller.
// ----------------------------------------------------------------------------
interface rbc_evt_if;
  logic                         valid;
  logic                         ready;
  logic [rbc_pkg::ModeW-1:0]    mode;
  logic [rbc_pkg::StatusW-1:0]  status_code;
  logic                         has_server_wait;
  logic [rbc_pkg::DelayW-1:0]   server_wait;

  modport source (output valid, mode, status_code, has_server_wait, server_wait,
                  input ready);
  modport sink   (input valid, mode, status_code, has_server_wait, server_wait,
                  output ready);
endinterface

interface rbc_res_if;
  logic                        valid;
  logic                        ready;
  logic                        retry_allowed;
  logic [rbc_pkg::DelayW-1:0]  wait_left;
  logic [rbc_pkg::CountW-1:0]  failures_seen;

  modport source (output valid, retry_allowed, wait_left, failures_seen,
                  input ready);
  modport sink   (input valid, retry_allowed, wait_left, failures_seen,
                  output ready);
endinterface

// ===== sv/rbc_step.sv =====
// ----------------------------------------------------------------------------
// rbc_step
// Next-state and result logic for one event: backoff scaling and clamp,
// stop decision, countdown and failure count update.
// ----------------------------------------------------------------------------
module rbc_step (
  input  rbc_pkg::cfg_t    cfg_i,
  input  rbc_pkg::state_t  state_i,
  input  rbc_pkg::item_t   item_i,
  output rbc_pkg::state_t  state_o,
  output rbc_pkg::result_t result_o
);
  import rbc_pkg::*;

  logic [ProdW-1:0]   product;
  logic [ScaledW-1:0] scaled;
  logic [ScaledW-1:0] min_ext;
  logic [ScaledW-1:0] max_ext;
  logic [ScaledW-1:0] raised;
  logic [DelayW-1:0]  clamped;
  logic [DelayW-1:0]  new_delay;
  logic [DelayW-1:0]  new_wait;
  logic               server_err;
  logic               stop;
  logic               allowed;

  // Q8.8 scaling, truncated, then raised to min and lowered to max (max wins)
  assign product = ProdW'(state_i.current_delay) * ProdW'(cfg_i.growth_factor);
  assign scaled  = product[ProdW-1:FracW];
  assign min_ext = ScaledW'(cfg_i.delay_floor);
  assign max_ext = ScaledW'(cfg_i.delay_ceiling);
  assign raised  = (scaled < min_ext) ? min_ext : scaled;
  assign clamped = (raised > max_ext) ? cfg_i.delay_ceiling : raised[DelayW-1:0];

  // First failure keeps the starting delay
  assign new_delay  = (state_i.failure_count != '0) ? clamped : state_i.current_delay;
  assign new_wait   = item_i.has_server_wait ? item_i.server_wait : new_delay;
  assign server_err = (item_i.status_code >= ServerErrLo) &&
                      (item_i.status_code <= ServerErrHi);
  assign stop       = (state_i.failure_count >= cfg_i.retry_limit) ||
                      (!cfg_i.retry_client_errors && !server_err);

  always_comb begin
    state_o = state_i;
    case (mode_e'(item_i.mode))
      MODE_TICK: begin
        if (state_i.countdown != '0) begin
          state_o.countdown = state_i.countdown - 1'b1;
        end
      end
      MODE_SUCCESS: begin
        state_o.current_delay = cfg_i.delay_floor;
        state_o.failure_count = '0;
        state_o.may_retry     = 1'b1;
      end
      MODE_FAILURE: begin
        // A stopped controller ignores failures entirely
        if (state_i.may_retry) begin
          state_o.current_delay = new_delay;
          state_o.may_retry     = !stop;
          if (!stop) begin
            state_o.countdown = new_wait;
          end
          if (state_i.failure_count != CountMax) begin
            state_o.failure_count = state_i.failure_count + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign allowed = (state_o.failure_count != '0) && state_o.may_retry;

  always_comb begin
    result_o.retry_allowed = allowed;
    result_o.wait_left     = allowed ? state_o.countdown : WaitNever;
    result_o.failures_seen = state_o.failure_count;
  end

endmodule

// ===== sv/retry_backoff_controller.sv =====
// ----------------------------------------------------------------------------
// retry_backoff_controller
// Exponential backoff retry tracker: one event in, one status result out.
// ----------------------------------------------------------------------------
// Timing: an accepted event lands in the input register, and the result
//   register loads from it once the result slot is free.
// Throughput: one event per cycle while the sink is ready; the state update
//   is one 16x16 multiply and the min/max clamp, all combinational.
// Reset: asynchronous, active low; config, state and valid flags return to
//   their defaults, delay to 1, count to 0, retrying enabled, countdown 0.
// ----------------------------------------------------------------------------
module retry_backoff_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rbc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rbc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  rbc_evt_if.sink                       evt_i,
  rbc_res_if.source                     res_o
);
  import rbc_pkg::*;

  cfg_t    cfg_q;
  state_t  state_q, state_d;
  item_t   item_q;
  result_t res_q, res_d;
  logic    in_valid_q;
  logic    out_valid_q;
  logic    advance;
  logic    in_accept;

  // --------------------------------------------------------------------------
  // Configuration registers: to be written only while no transaction is in flight
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delay_floor         <= MinDelayRst;
      cfg_q.delay_ceiling       <= MaxDelayRst;
      cfg_q.growth_factor       <= FactorRst;
      cfg_q.retry_limit         <= MaxRetryRst;
      cfg_q.retry_client_errors <= ClientErrRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_DELAY:      cfg_q.delay_floor   <= cfg_wdata_i[DelayW-1:0];
        CFG_MAX_DELAY:      cfg_q.delay_ceiling <= cfg_wdata_i[DelayW-1:0];
        CFG_BACKOFF_FACTOR: cfg_q.growth_factor <= cfg_wdata_i[FactorW-1:0];
        CFG_MAX_RETRIES:    cfg_q.retry_limit   <= cfg_wdata_i[CountW-1:0];
        CFG_RETRY_CLIENT:   cfg_q.retry_client_errors <= cfg_wdata_i[0];
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: the input stage advances whenever the result register is
  // empty or being drained this cycle, so events flow every cycle while the
  // sink is ready; a stalled result holds the next event in the input register.
  // --------------------------------------------------------------------------
  assign advance     = in_valid_q && (!out_valid_q || res_o.ready);
  assign evt_i.ready = !in_valid_q || advance;
  assign in_accept   = evt_i.valid && evt_i.ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (evt_i.ready) begin
      in_valid_q <= evt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.mode            <= evt_i.mode;
      item_q.status_code     <= evt_i.status_code;
      item_q.has_server_wait <= evt_i.has_server_wait;
      item_q.server_wait     <= evt_i.server_wait;
    end
  end

  // --------------------------------------------------------------------------
  // Event evaluation: state and result are both computed from the held event
  // --------------------------------------------------------------------------
  rbc_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Controller state: commit only when the event moves into the result slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.current_delay <= MinDelayRst;
      state_q.failure_count <= '0;
      state_q.may_retry     <= 1'b1;
      state_q.countdown     <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register: hold while the sink stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.retry_allowed = res_q.retry_allowed;
  assign res_o.wait_left     = res_q.wait_left;
  assign res_o.failures_seen = res_q.failures_seen;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef ASSERT_OFF
  // A success always clears the count, re-enables retrying and restores min delay
  a_success_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (item_q.mode == MODE_SUCCESS) |=>
      (state_q.failure_count == '0) && state_q.may_retry &&
      (state_q.current_delay == $past(cfg_q.delay_floor)))
    else $error("success did not restart the backoff state");

  // Every evaluated event produces a pending result
  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("evaluated event produced no result");

  // A held event is not lost while the result slot is blocked
  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(item_q))
    else $error("blocked event was dropped or changed");

  // State moves only when an event is evaluated
  a_state_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("controller state changed without an event");
`endif

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for retry_backoff_controller. A short stimulus table
// walks the reset defaults and the corner cases, then random phases with new
// register settings drive ticks, successes and failures. Every transaction is
// predicted on acceptance and each result is compared field by field.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rbc_pkg::*;

  localparam int ClkPeriod     = 20;
  localparam int ResetCycles   = 4;
  localparam int TargetEvents  = 1250;
  localparam int PhaseItems    = 150;
  localparam int SatItems      = 300;
  localparam int IdlePct       = 17;
  localparam int DrainHold     = 4;
  localparam int WatchdogLimit = 2000;

  // Mode three has no name in the package; the block must ignore it.
  localparam logic [ModeW-1:0] MODE_RESERVED = 2'd3;

  // One row of the stimulus table: the event, and a hand-written result
  // where one is given (otherwise the predictor decides).
  typedef struct {
    item_t   ev;
    bit      given;
    result_t value;
  } vector_t;

  typedef struct packed {
    bit      given;
    result_t value;
  } known_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  rbc_evt_if evt_if ();
  rbc_res_if res_if ();

  retry_backoff_controller u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .evt_i       (evt_if),
    .res_o       (res_if)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Predictor copy of the registers and the retry state.
  cfg_t   regs;
  state_t tracker;

  result_t     outcome_q [$];   // results still owed by the block
  known_t      known_q [$];     // per sent event: hand-written result, if any
  int unsigned live_events  = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned quiet_cycles = 0;
  bit          steady       = 1'b0;

  vector_t directed_vec [0:24] = '{
    // right after reset: a tick and the reserved mode report "never"
    '{'{MODE_TICK,     10'd0,   1'b0, 16'd0},    1'b1, '{1'b0, WaitNever, 8'd0}},
    '{'{MODE_RESERVED, 10'd999, 1'b1, 16'hFFFF}, 1'b1, '{1'b0, WaitNever, 8'd0}},
    // first failure keeps the min delay unscaled, then count down to zero
    '{'{MODE_FAILURE,  10'd503, 1'b0, 16'd0},    1'b1, '{1'b1, 16'd1, 8'd1}},
    '{'{MODE_TICK,     10'd0,   1'b0, 16'd0},    1'b1, '{1'b1, 16'd0, 8'd1}},
    '{'{MODE_TICK,     10'd0,   1'b0, 16'd0},    1'b1, '{1'b1, 16'd0, 8'd1}},
    '{'{MODE_FAILURE,  10'd500, 1'b0, 16'd0},    1'b0, '0},
    // server wait of all ones passes through and reads like never
    '{'{MODE_FAILURE,  10'd599, 1'b1, 16'hFFFF}, 1'b1, '{1'b1, WaitNever, 8'd3}},
    // retry limit reached, then a failure while stopped changes nothing
    '{'{MODE_FAILURE,  10'd502, 1'b0, 16'd0},    1'b0, '0},
    '{'{MODE_FAILURE,  10'd503, 1'b1, 16'd5},    1'b0, '0},
    '{'{MODE_TICK,     10'd0,   1'b0, 16'd0},    1'b0, '0},
    '{'{MODE_SUCCESS,  10'd0,   1'b0, 16'd0},    1'b1, '{1'b0, WaitNever, 8'd0}},
    // statuses outside 5xx stop retrying at once
    '{'{MODE_FAILURE,  10'd404, 1'b0, 16'd0},    1'b0, '0},
    '{'{MODE_FAILURE,  10'd0,   1'b1, 16'd1234}, 1'b0, '0},
    '{'{MODE_SUCCESS,  10'd999, 1'b1, 16'hFFFF}, 1'b0, '0},
    '{'{MODE_FAILURE,  10'd600, 1'b1, 16'd7},    1'b0, '0},
    '{'{MODE_SUCCESS,  10'd0,   1'b0, 16'd0},    1'b0, '0},
    '{'{MODE_FAILURE,  10'd499, 1'b0, 16'd0},    1'b0, '0},
    '{'{MODE_SUCCESS,  10'd0,   1'b0, 16'd0},    1'b0, '0},
    '{'{MODE_FAILURE,  10'd999, 1'b1, 16'd9},    1'b0, '0},
    '{'{MODE_SUCCESS,  10'd0,   1'b0, 16'd0},    1'b0, '0},
    // server wait of zero, then a large one ticking down
    '{'{MODE_FAILURE,  10'd550, 1'b1, 16'd0},    1'b0, '0},
    '{'{MODE_TICK,     10'd0,   1'b0, 16'd0},    1'b0, '0},
    '{'{MODE_FAILURE,  10'd501, 1'b1, 16'h8000}, 1'b0, '0},
    '{'{MODE_TICK,     10'd0,   1'b0, 16'd0},    1'b0, '0},
    '{'{MODE_SUCCESS,  10'd0,   1'b0, 16'd0},    1'b0, '0}
  };

  // Advance the predicted retry state by one event and return its report.
  function automatic result_t next_outcome(input item_t ev);
    logic [ProdW-1:0]   prod;
    logic [ScaledW-1:0] scaled;
    logic [DelayW-1:0]  wait_ticks;
    result_t            res;
    case (ev.mode)
      MODE_TICK: begin
        if (tracker.countdown != '0) tracker.countdown = tracker.countdown - 1'b1;
      end
      MODE_SUCCESS: begin
        tracker.current_delay = regs.delay_floor;
        tracker.failure_count = '0;
        tracker.may_retry     = 1'b1;
      end
      MODE_FAILURE: begin
        if (tracker.may_retry) begin
          // scale from the second failure on; max is applied last so it wins
          if (tracker.failure_count != '0) begin
            prod   = ProdW'(tracker.current_delay) * ProdW'(regs.growth_factor);
            scaled = ScaledW'(prod >> FracW);
            if (scaled < ScaledW'(regs.delay_floor)) scaled = ScaledW'(regs.delay_floor);
            if (scaled > ScaledW'(regs.delay_ceiling)) scaled = ScaledW'(regs.delay_ceiling);
            tracker.current_delay = scaled[DelayW-1:0];
          end
          wait_ticks = ev.has_server_wait ? ev.server_wait : tracker.current_delay;
          if (tracker.failure_count >= regs.retry_limit) tracker.may_retry = 1'b0;
          if (!regs.retry_client_errors &&
              !(ev.status_code >= ServerErrLo && ev.status_code <= ServerErrHi)) begin
            tracker.may_retry = 1'b0;
          end
          if (tracker.may_retry) tracker.countdown = wait_ticks;
          if (tracker.failure_count != CountMax) begin
            tracker.failure_count = tracker.failure_count + 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.retry_allowed = (tracker.failure_count != '0) && tracker.may_retry;
    res.wait_left     = res.retry_allowed ? tracker.countdown : WaitNever;
    res.failures_seen = tracker.failure_count;
    return res;
  endfunction

  // Draw one event. Failures lean toward 5xx and short server waits so that
  // retry sequences run deep; the fields of other modes stay random.
  function automatic item_t random_event(input int unsigned fail_pct,
                                         input int unsigned ok_pct);
    item_t       ev;
    int unsigned r;
    r                  = $urandom_range(99);
    ev.status_code     = 10'($urandom_range(999));
    ev.has_server_wait = 1'($urandom);
    ev.server_wait     = 16'($urandom);
    if (r < 3) begin
      ev.mode = MODE_RESERVED;
    end else if (r < 3 + fail_pct) begin
      ev.mode = MODE_FAILURE;
      case ($urandom_range(9))
        0:       ev.status_code = ServerErrLo;
        1:       ev.status_code = ServerErrHi;
        2, 3:    ;
        default: ev.status_code = 10'($urandom_range(ServerErrLo, ServerErrHi));
      endcase
      ev.has_server_wait = ($urandom_range(9) < 3);
      case ($urandom_range(7))
        0:       ev.server_wait = WaitNever;
        1, 2, 3: ev.server_wait = 16'($urandom_range(20));
        default: ;
      endcase
    end else if (r < 3 + fail_pct + ok_pct) begin
      ev.mode = MODE_SUCCESS;
    end else begin
      ev.mode = MODE_TICK;
    end
    return ev;
  endfunction

  // Register settings per phase: three fixed corners, then random draws.
  function automatic cfg_t pick_settings(input int unsigned phase);
    cfg_t c;
    case (phase)
      // min above max, largest factor
      0: c = '{16'd300, 16'd100, 16'hFFFF, 8'd5, 1'b1};
      // zero factor collapses the delay to a zero min; no retries at all
      1: c = '{16'd0, 16'hFFFF, 16'd0, 8'd0, 1'b0};
      // retry limit of 254: long enough to saturate the failure count
      2: c = '{16'd2, 16'hFFFF, 16'd384, 8'd254, 1'b1};
      default: begin
        case ($urandom_range(9))
          0:       c.delay_floor = '0;
          1:       c.delay_floor = '1;
          2, 3:    c.delay_floor = 16'($urandom);
          default: c.delay_floor = 16'($urandom_range(1, 40));
        endcase
        case ($urandom_range(9))
          0:       c.delay_ceiling = '0;
          1, 2:    c.delay_ceiling = '1;
          3:       c.delay_ceiling = 16'($urandom);
          default: c.delay_ceiling = 16'($urandom_range(40, 3000));
        endcase
        case ($urandom_range(9))
          0:       c.growth_factor = '0;
          1:       c.growth_factor = '1;
          2:       c.growth_factor = 16'd256;
          3:       c.growth_factor = 16'($urandom);
          default: c.growth_factor = 16'($urandom_range(128, 1024));
        endcase
        case ($urandom_range(9))
          0:       c.retry_limit = '0;
          1:       c.retry_limit = 8'd254;
          default: c.retry_limit = 8'($urandom_range(1, 10));
        endcase
        c.retry_client_errors = 1'($urandom);
      end
    endcase
    return c;
  endfunction

  // Present one event and hold it until the block takes it. The source may
  // idle first unless the steady stretch is on.
  task automatic send_event(input item_t ev, input bit given, input result_t value);
    known_t k;
    while (!steady && $urandom_range(99) < IdlePct) begin
      evt_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    k.given = given;
    k.value = value;
    known_q.push_back(k);
    evt_if.valid           <= 1'b1;
    evt_if.mode            <= ev.mode;
    evt_if.status_code     <= ev.status_code;
    evt_if.has_server_wait <= ev.has_server_wait;
    evt_if.server_wait     <= ev.server_wait;
    @(posedge clk_i);
    while (!evt_if.ready) @(posedge clk_i);
  endtask

  // Hold the source until every owed result is back, then let the pipeline
  // settle.
  task automatic drain_outcomes();
    @(posedge clk_i);
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (DrainHold) @(posedge clk_i);
  endtask

  // Write all five registers back to back; the block is idle here.
  task automatic load_settings(input cfg_t c);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_MIN_DELAY;
    cfg_wdata_i <= c.delay_floor;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_MAX_DELAY;
    cfg_wdata_i <= c.delay_ceiling;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_BACKOFF_FACTOR;
    cfg_wdata_i <= c.growth_factor;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_MAX_RETRIES;
    cfg_wdata_i <= CfgDataW'(c.retry_limit);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_RETRY_CLIENT;
    cfg_wdata_i <= CfgDataW'(c.retry_client_errors);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    regs = c;
  endtask

  // Result side: drop ready at random on IdlePct percent of clocks, except in
  // the steady stretch.
  always @(posedge clk_i) begin
    res_if.ready <= steady || ($urandom_range(99) >= IdlePct);
  end

  // Predict on every accepted event, check on every accepted result. Events
  // are handled first in case a result ever leaves in the same cycle.
  always @(posedge clk_i) begin : score
    known_t  k;
    result_t want;
    item_t   ev;
    if (rst_ni) begin
      if (evt_if.valid && evt_if.ready) begin
        ev.mode            = evt_if.mode;
        ev.status_code     = evt_if.status_code;
        ev.has_server_wait = evt_if.has_server_wait;
        ev.server_wait     = evt_if.server_wait;
        live_events++;
        want = next_outcome(ev);
        k    = known_q.pop_front();
        outcome_q.push_back(k.given ? k.value : want);
      end
      if (res_if.valid && res_if.ready) begin
        if (outcome_q.size() == 0) begin
          $error("result with no event pending: retry_allowed %0b wait_left %0d failures_seen %0d",
                 res_if.retry_allowed, res_if.wait_left, res_if.failures_seen);
          mismatch_cnt++;
        end else begin
          want = outcome_q.pop_front();
          if (res_if.retry_allowed !== want.retry_allowed) begin
            $error("retry_allowed: expected %0b, got %0b",
                   want.retry_allowed, res_if.retry_allowed);
            mismatch_cnt++;
          end
          if (res_if.wait_left !== want.wait_left) begin
            $error("wait_left: expected %0d, got %0d", want.wait_left, res_if.wait_left);
            mismatch_cnt++;
          end
          if (res_if.failures_seen !== want.failures_seen) begin
            $error("failures_seen: expected %0d, got %0d",
                   want.failures_seen, res_if.failures_seen);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  // Watchdog: stop the run if nothing moves for too long.
  always @(posedge clk_i) begin
    if ((evt_if.valid && evt_if.ready) || (res_if.valid && res_if.ready) || cfg_we_i) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    cfg_t        c;
    item_t       ev;
    int unsigned phase;
    int unsigned len;
    int unsigned fail_pct;
    int unsigned ok_pct;

    rst_ni                 <= 1'b0;
    cfg_we_i               <= 1'b0;
    cfg_idx_i              <= CFG_MIN_DELAY;
    cfg_wdata_i            <= '0;
    evt_if.valid           <= 1'b0;
    evt_if.mode            <= MODE_TICK;
    evt_if.status_code     <= '0;
    evt_if.has_server_wait <= 1'b0;
    evt_if.server_wait     <= '0;

    regs                  = '{MinDelayRst, MaxDelayRst, FactorRst, MaxRetryRst, ClientErrRst};
    tracker.current_delay = MinDelayRst;
    tracker.failure_count = '0;
    tracker.may_retry     = 1'b1;
    tracker.countdown     = '0;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the stimulus table under the reset settings.
    foreach (directed_vec[i]) begin
      send_event(directed_vec[i].ev, directed_vec[i].given, directed_vec[i].value);
    end
    evt_if.valid <= 1'b0;

    // Random phases: drain, load new settings, then a burst of events.
    phase = 0;
    while (live_events < TargetEvents) begin
      drain_outcomes();
      c = pick_settings(phase);
      load_settings(c);
      steady   = (phase == 3);
      len      = PhaseItems;
      fail_pct = 25;
      ok_pct   = 6;
      // with a huge retry limit, hammer failures without any success so the
      // count runs into saturation
      if (c.retry_limit >= 8'd200 && c.retry_client_errors) begin
        len      = SatItems;
        fail_pct = 90;
        ok_pct   = 0;
      end
      // usually restart so the new min delay applies; otherwise carry the
      // old delay and count over into the new settings
      if (ok_pct == 0 || $urandom_range(9) < 7) begin
        ev      = random_event(0, 0);
        ev.mode = MODE_SUCCESS;
        send_event(ev, 1'b0, '0);
      end
      for (int n = 0; n < len && live_events < TargetEvents; n++) begin
        send_event(random_event(fail_pct, ok_pct), 1'b0, '0);
      end
      evt_if.valid <= 1'b0;
      steady = 1'b0;
      phase++;
    end

    drain_outcomes();
    if (mismatch_cnt == 0 && outcome_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
